@@ src/cov_pkg.sv @@
`default_nettype none
package cov_pkg;
  localparam int CONTIG_W = 12;
  localparam int LEN_W = 32;
  localparam int OFF_W = 31;
  localparam int IDX_W = 10;
  localparam int COST_W = 48;

  typedef enum logic [1:0] {
    REQ_SEQ = 2'd0,
    REQ_LEN = 2'd1,
    REQ_PAIR = 2'd2,
    REQ_EMIT = 2'd3
  } req_t;

  // One input item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [CONTIG_W-1:0] seq_contig;
    logic [LEN_W-1:0] contig_len;
    logic [CONTIG_W-1:0] first_ref;
    logic [OFF_W-1:0] first_offset;
    logic [CONTIG_W-1:0] second_ref;
    logic [OFF_W-1:0] second_offset;
    logic [IDX_W-1:0] emit_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [CONTIG_W-1:0] out_contig;
    logic reversed;
  } out_item_t;

  // Saturating add of a signed delta to a 48-bit signed cost.
  function automatic logic signed [COST_W-1:0] sat_add(
    input logic signed [COST_W-1:0] acc, input logic signed [33:0] delta);
    logic signed [COST_W:0] s;
    s = {acc[COST_W-1], acc} + {{(COST_W-33){delta[33]}}, delta};
    if (s[COST_W] != s[COST_W-1])
      sat_add = s[COST_W] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
    else
      sat_add = s[COST_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ src/cov_if.sv @@
`default_nettype none
interface cov_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/cov_queue.sv @@
`default_nettype none
module cov_queue import cov_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire in_item_t push_data,
  output logic full,
  input wire logic pop,
  output logic empty,
  output in_item_t pop_data
);
  // Two-entry queue between front and back.
  in_item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign pop_data = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ src/cov_back.sv @@
`default_nettype none
module cov_back import cov_pkg::*; #(
  parameter int MAX_IDS = 4096,
  parameter int SEQ_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_empty,
  input wire in_item_t q_data,
  output logic q_pop,
  output logic busy,
  cov_if.source res
);
  localparam int PW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW = $clog2(SEQ_DEPTH + 1);
  localparam int LCW = $clog2(MAX_IDS + 1);
  localparam int CLR_N = (MAX_IDS > SEQ_DEPTH) ? MAX_IDS : SEQ_DEPTH;
  localparam int CLRW = $clog2(CLR_N);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEQ_RD, S_SEQ_WR, S_LEN_RD, S_LEN_WR, S_PA_RD, S_PB_RD,
    S_WR_A, S_COST_B, S_WR_B, S_EMIT_RD, S_EMIT_OUT
  } state_t;
  state_t state;

  // Stores. The map holds a valid bit beside the position.
  logic [PW:0] map_mem [MAX_IDS];
  logic [CONTIG_W-1:0] seq_mem [SEQ_DEPTH];
  logic [LEN_W-1:0] len_mem [SEQ_DEPTH];
  logic [COST_W-1:0] fwd_mem [SEQ_DEPTH];
  logic [COST_W-1:0] rev_mem [SEQ_DEPTH];

  logic [CLRW-1:0] clr_id;
  logic [CW-1:0] seq_count;
  logic [LCW-1:0] len_counter;
  in_item_t cur;
  logic [PW:0] map_q;
  logic [PW-1:0] pa, pb;
  logic [LEN_W-1:0] len_q;
  logic [COST_W-1:0] fwd_q, rev_q;
  logic [CONTIG_W-1:0] seq_q;
  logic [PW-1:0] raddr_p;
  logic [IW-1:0] raddr_id;
  logic signed [33:0] dfa, dra;
  logic signed [33:0] o_s, l_s;
  logic gt, side_b;
  logic emit_ok;
  logic clr_map, clr_pos, clr_last;

  assign busy = state != S_IDLE;
  assign q_pop = (state == S_IDLE) && !q_empty;

  // Id fits the map.
  function automatic logic id_ok(input logic [CONTIG_W-1:0] id);
    id_ok = {{32-CONTIG_W{1'b0}}, id} < 32'(MAX_IDS);
  endfunction

  // Deltas for the position being written (a, then b) from length, offset, ordering.
  // The registered reads in front of each write come from the position written.
  assign gt = pa > pb;
  assign side_b = (state == S_WR_B);
  assign o_s = side_b ? 34'(cur.second_offset) : 34'(cur.first_offset);
  assign l_s = 34'(len_q);
  always_comb begin
    if (gt ^ side_b) begin
      dfa = l_s - o_s;
      dra = o_s;
    end else begin
      dfa = o_s;
      dra = l_s - o_s;
    end
  end

  always_ff @(posedge clk) begin
    map_q <= map_mem[raddr_id];
    len_q <= len_mem[raddr_p];
    fwd_q <= fwd_mem[raddr_p];
    rev_q <= rev_mem[raddr_p];
    seq_q <= seq_mem[raddr_p];
  end

  // Read address selection. Addresses are held while a state uses its read data.
  always_comb begin
    raddr_id = '0;
    raddr_p = pa;
    case (state)
      S_IDLE: begin
        if (q_data.req_type == REQ_SEQ) raddr_id = IW'(q_data.seq_contig);
        else if (q_data.req_type == REQ_LEN) raddr_id = IW'(len_counter);
        else raddr_id = IW'(q_data.first_ref);
        raddr_p = PW'(q_data.emit_index);
      end
      S_SEQ_RD: raddr_id = IW'(cur.seq_contig);
      S_LEN_RD: raddr_id = IW'(len_counter);
      S_PA_RD: raddr_id = IW'(cur.second_ref);
      S_COST_B: raddr_p = pb;
      S_EMIT_RD, S_EMIT_OUT: raddr_p = PW'(cur.emit_index);
      default: raddr_p = pa;
    endcase
  end

  assign emit_ok = {{(32-IDX_W){1'b0}}, cur.emit_index} < 32'(SEQ_DEPTH);

  // Clearing pass covers the map and the position-indexed stores alike.
  assign clr_map = {{(32-CLRW){1'b0}}, clr_id} < 32'(MAX_IDS);
  assign clr_pos = {{(32-CLRW){1'b0}}, clr_id} < 32'(SEQ_DEPTH);
  assign clr_last = {{(32-CLRW){1'b0}}, clr_id} == 32'(CLR_N - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_id <= '0;
      seq_count <= '0;
      len_counter <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_map) map_mem[IW'(clr_id)] <= '0;
          if (clr_pos) begin
            seq_mem[PW'(clr_id)] <= '0;
            len_mem[PW'(clr_id)] <= '0;
            fwd_mem[PW'(clr_id)] <= '0;
            rev_mem[PW'(clr_id)] <= '0;
          end
          clr_id <= clr_id + 1'b1;
          if (clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_data;
            case (q_data.req_type)
              REQ_SEQ: state <= S_SEQ_RD;
              REQ_LEN: state <= S_LEN_RD;
              REQ_PAIR: state <= S_PA_RD;
              default: state <= S_EMIT_RD;
            endcase
          end
        end
        S_SEQ_RD: state <= S_SEQ_WR;
        S_SEQ_WR: begin
          if ({{(32-CW){1'b0}}, seq_count} < 32'(SEQ_DEPTH) && id_ok(cur.seq_contig)) begin
            seq_mem[PW'(seq_count)] <= cur.seq_contig;
            if (!map_q[PW])
              map_mem[IW'(cur.seq_contig)] <= {1'b1, PW'(seq_count)};
            seq_count <= seq_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_LEN_RD: state <= S_LEN_WR;
        S_LEN_WR: begin
          if ({{(32-LCW){1'b0}}, len_counter} < 32'(MAX_IDS)) begin
            if (map_q[PW]) len_mem[map_q[PW-1:0]] <= cur.contig_len;
            len_counter <= len_counter + 1'b1;
          end
          state <= S_IDLE;
        end
        // First lookup is in map_q; the second lookup is being read.
        S_PA_RD: begin
          pa <= map_q[PW-1:0];
          if (!map_q[PW] || !id_ok(cur.first_ref)) state <= S_IDLE;
          else state <= S_PB_RD;
        end
        // Second lookup is in map_q; position a's stores are being read.
        S_PB_RD: begin
          pb <= map_q[PW-1:0];
          if (!map_q[PW] || !id_ok(cur.second_ref)) state <= S_IDLE;
          else state <= S_WR_A;
        end
        S_WR_A: begin
          fwd_mem[pa] <= sat_add(fwd_q, dfa);
          rev_mem[pa] <= sat_add(rev_q, dra);
          state <= S_COST_B;
        end
        // Position b is read after the side-a write landed.
        S_COST_B: state <= S_WR_B;
        S_WR_B: begin
          fwd_mem[pb] <= sat_add(fwd_q, dfa);
          rev_mem[pb] <= sat_add(rev_q, dra);
          state <= S_IDLE;
        end
        S_EMIT_RD: state <= S_EMIT_OUT;
        S_EMIT_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.payload.out_index <= cur.emit_index;
            res.payload.out_contig <= emit_ok ? seq_q : '0;
            res.payload.reversed <= emit_ok &&
              ($signed(rev_q) < $signed(fwd_q));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res.valid && res.ready && state != S_EMIT_OUT) res.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ src/contig_orientation_vote_unit.sv @@
`default_nettype none
// The back end takes one item at a time from the two-entry queue and finishes it (a presented
// result or a finished update; a read pair ends with its side-b cost write) before the next;
// the sequence is set by the back end's sequencer over its single-port stores, and a stalled
// result holds it.
// Reset: synchronous; a clearing pass over the larger of MAX_IDS and SEQ_DEPTH entries
// then runs while items wait in the queue.
module contig_orientation_vote_unit import cov_pkg::*; #(
  parameter int MAX_IDS = 4096,
  parameter int SEQ_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst,
  cov_if.sink in_ch,
  cov_if.source out_ch
);
  logic q_full, q_empty, q_pop, busy;
  in_item_t q_data;

  assign in_ch.ready = !q_full;

  cov_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_ch.valid && !q_full), .push_data(in_ch.payload), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data)
  );

  cov_back #(.MAX_IDS(MAX_IDS), .SEQ_DEPTH(SEQ_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .busy(busy), .res(out_ch)
  );

  // The back end takes an item from the queue only while it is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !busy) else $error("pop while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result lost");
  // A waiting result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.payload))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
